// ===== rtl/sobel_edge_magnitude_3x3_assert.svh =====
// Assertion macros shared by the edge magnitude blocks.
`ifndef SOBEL_EDGE_MAGNITUDE_3X3_ASSERT_SVH
`define SOBEL_EDGE_MAGNITUDE_3X3_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SBL_ASSERT_IMPL(lbl_, clk_, rstn_, ante_, cons_, msg_) \
  lbl_: assert property (@(posedge clk_) disable iff (!rstn_) (ante_) |-> (cons_)) \
    else $error(msg_);

// Next-cycle implication, disabled while reset is asserted.
`define SBL_ASSERT_NEXT(lbl_, clk_, rstn_, ante_, cons_, msg_) \
  lbl_: assert property (@(posedge clk_) disable iff (!rstn_) (ante_) |=> (cons_)) \
    else $error(msg_);

`endif

// ===== rtl/sbl_pkg.sv =====
// Shared types and constants of the Sobel edge magnitude block.
package sbl_pkg;

  localparam int unsigned PIX_W           = 8;
  localparam int unsigned CFG_WIDTH_BITS  = 12;
  localparam int unsigned CFG_HEIGHT_BITS = 13;
  localparam int unsigned WIN_TAPS        = 9;
  localparam int unsigned SIDE_WEIGHT     = 2;
  localparam int unsigned QUEUE_DEPTH     = 4;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  typedef enum logic [1:0] {
    FS_TOTAL,
    FS_CLAMP,
    FS_DIV,
    FS_RUN
  } sbl_front_e;

  typedef enum logic [2:0] {
    BS_IDLE,
    BS_READ,
    BS_GRAD,
    BS_SQX,
    BS_SQY,
    BS_SUM,
    BS_ROOT,
    BS_HOLD
  } sbl_back_e;

  typedef struct packed {
    logic border;
    logic last;
    logic right_ok;
    logic bl_ok;
    logic b_ok;
    logic br_ok;
  } sbl_flags_t;

endpackage

// ===== rtl/sbl_if.sv =====
// Valid/ready stream interfaces for pixel input and edge results.
interface sbl_in_if;
  logic                       valid;
  logic                       ready;
  logic                       op;
  logic [sbl_pkg::PIX_W-1:0]  pixel_in;

  modport source (output valid, output op, output pixel_in, input ready);
  modport sink (input valid, input op, input pixel_in, output ready);
endinterface

interface sbl_out_if;
  logic                       valid;
  logic                       ready;
  logic [sbl_pkg::PIX_W-1:0]  edge_out;
  logic                       frame_last;

  modport source (output valid, output edge_out, output frame_last, input ready);
  modport sink (input valid, input edge_out, input frame_last, output ready);
endinterface

// ===== rtl/sbl_front.sv =====
// Front end: accepts pixels and flushes, tracks raster position and issues window commands.
`include "sobel_edge_magnitude_3x3_assert.svh"

module sbl_front #(
  parameter int MAXW = 2048,
  parameter int MAXH = 4096,
  parameter int AW   = 13
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_wr_i,
  input  logic [$clog2(MAXW+1)-1:0]     width_i,
  input  logic [$clog2(MAXH+1)-1:0]     height_i,
  sbl_in_if.sink                        pix_i,
  input  logic                          full_i,
  output logic                          push_o,
  output sbl_pkg::sbl_flags_t           cmd_flags_o,
  output logic [AW-1:0]                 cmd_center_o,
  output logic                          mem_we_o,
  output logic [AW-1:0]                 mem_waddr_o,
  output logic [sbl_pkg::PIX_W-1:0]     mem_wdata_o
);

  localparam int WD   = $clog2(MAXW + 1);
  localparam int HD   = $clog2(MAXH + 1);
  localparam int PD   = WD + HD;
  localparam int CNTW = $clog2(MAXW + 3);
  localparam int COLW = $clog2(MAXW);
  localparam int ROWW = $clog2(MAXH);
  localparam int DCW  = $clog2(PD);

  sbl_pkg::sbl_front_e state_q, state_d;

  logic [CNTW-1:0] pending_q;
  logic [AW-1:0]   head_q;
  logic [PD-1:0]   pos_q;
  logic [PD-1:0]   total_q;
  logic [ROWW-1:0] row_q;
  logic [COLW-1:0] col_q;
  logic [PD-1:0]   dvd_q;
  logic [WD-1:0]   rem_q;
  logic [PD-1:0]   quo_q;
  logic [DCW-1:0]  dcnt_q;

  logic            accept;
  logic            is_pix;
  logic            emit;
  logic [CNTW-1:0] w_c;
  logic [CNTW-1:0] pnew;
  logic [CNTW-1:0] pend_e;
  logic [AW-1:0]   head_n;
  logic [HD-1:0]   row_e;
  logic [WD-1:0]   col_e;
  logic            col_wrap;
  logic            row_wrap;
  logic [WD:0]     div_r;
  logic [WD:0]     div_diff;
  logic            div_ge;
  logic [WD-1:0]   rem_n;
  logic [PD-1:0]   quo_n;

  assign accept   = pix_i.valid && pix_i.ready;
  assign is_pix   = (pix_i.op == sbl_pkg::OP_PIXEL);
  assign w_c      = CNTW'(width_i);
  assign pnew     = pending_q + CNTW'(1);
  assign pend_e   = is_pix ? pnew : pending_q;
  assign emit     = is_pix ? (pnew >= w_c + CNTW'(2)) : (pending_q != '0);
  assign head_n   = is_pix ? head_q + AW'(1) : head_q;
  assign row_e    = HD'(row_q);
  assign col_e    = WD'(col_q);
  assign col_wrap = (col_e == width_i - WD'(1));
  assign row_wrap = (row_e == height_i - HD'(1));

  assign div_r    = {rem_q, dvd_q[PD-1]};
  assign div_diff = div_r - {1'b0, width_i};
  assign div_ge   = (div_r >= {1'b0, width_i});
  assign rem_n    = div_ge ? div_diff[WD-1:0] : div_r[WD-1:0];
  assign quo_n    = {quo_q[PD-2:0], div_ge};

  always_comb begin
    state_d = state_q;
    case (state_q)
      sbl_pkg::FS_TOTAL: state_d = sbl_pkg::FS_CLAMP;
      sbl_pkg::FS_CLAMP: state_d = sbl_pkg::FS_DIV;
      sbl_pkg::FS_DIV: begin
        if (dcnt_q == '0) begin
          state_d = sbl_pkg::FS_RUN;
        end
      end
      sbl_pkg::FS_RUN:   state_d = sbl_pkg::FS_RUN;
      default:           state_d = sbl_pkg::FS_TOTAL;
    endcase
    if (cfg_wr_i) begin
      state_d = sbl_pkg::FS_TOTAL;
    end
  end

  always_comb begin
    pix_i.ready          = (state_q == sbl_pkg::FS_RUN) && !full_i;
    push_o               = accept && emit;
    mem_we_o             = accept && is_pix;
    mem_waddr_o          = head_q;
    mem_wdata_o          = pix_i.pixel_in;
    cmd_center_o         = head_n - AW'(pend_e);
    cmd_flags_o.border   = (row_e == '0) || row_wrap || (col_e == '0) || col_wrap;
    cmd_flags_o.last     = row_wrap && col_wrap;
    cmd_flags_o.right_ok = (pend_e >= CNTW'(2));
    cmd_flags_o.bl_ok    = (pend_e >= w_c);
    cmd_flags_o.b_ok     = (pend_e >= w_c + CNTW'(1));
    cmd_flags_o.br_ok    = (pend_e >= w_c + CNTW'(2));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= sbl_pkg::FS_TOTAL;
      pending_q <= '0;
      head_q    <= '0;
      pos_q     <= '0;
      total_q   <= '0;
      row_q     <= '0;
      col_q     <= '0;
      dvd_q     <= '0;
      rem_q     <= '0;
      quo_q     <= '0;
      dcnt_q    <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        sbl_pkg::FS_TOTAL: begin
          total_q <= PD'(width_i) * PD'(height_i);
        end
        sbl_pkg::FS_CLAMP: begin
          if (pos_q >= total_q) begin
            pos_q <= '0;
            dvd_q <= '0;
          end else begin
            dvd_q <= pos_q;
          end
          rem_q  <= '0;
          quo_q  <= '0;
          dcnt_q <= DCW'(PD - 1);
        end
        sbl_pkg::FS_DIV: begin
          dvd_q  <= {dvd_q[PD-2:0], 1'b0};
          rem_q  <= rem_n;
          quo_q  <= quo_n;
          dcnt_q <= dcnt_q - DCW'(1);
          if (dcnt_q == '0) begin
            row_q <= ROWW'(quo_n);
            col_q <= COLW'(rem_n);
          end
        end
        sbl_pkg::FS_RUN: begin
          if (accept) begin
            head_q    <= head_n;
            pending_q <= emit ? pend_e - CNTW'(1) : pend_e;
            if (emit) begin
              col_q <= col_wrap ? '0 : col_q + COLW'(1);
              if (col_wrap) begin
                row_q <= row_wrap ? '0 : row_q + ROWW'(1);
              end
              pos_q <= (col_wrap && row_wrap) ? '0 : pos_q + PD'(1);
            end
          end
        end
        default: begin
          total_q <= '0;
        end
      endcase
    end
  end

  `SBL_ASSERT_IMPL(a_pos_in_frame, clk_i, rst_ni, state_q == sbl_pkg::FS_RUN,
                   (col_e < width_i) && (row_e < height_i), "raster position outside frame")
  `SBL_ASSERT_NEXT(a_cfg_resync, clk_i, rst_ni, cfg_wr_i, state_q == sbl_pkg::FS_TOTAL,
                   "configuration write did not restart position resync")
  `SBL_ASSERT_IMPL(a_pending_bound, clk_i, rst_ni, 1'b1, pending_q <= CNTW'(MAXW + 1),
                   "pending count beyond the line reach")

endmodule

// ===== rtl/sbl_fifo.sv =====
// Short command queue between the front end and the window engine.
module sbl_fifo #(
  parameter int DW = 19
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic [DW-1:0] data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic [DW-1:0] data_o,
  output logic          empty_o
);

  localparam int DEPTH = sbl_pkg::QUEUE_DEPTH;
  localparam int PW    = $clog2(DEPTH);

  logic [DW-1:0] entry_q [DEPTH];
  logic [PW-1:0] wr_ptr_q;
  logic [PW-1:0] rd_ptr_q;
  logic [PW:0]   count_q;

  assign full_o  = (count_q == (PW+1)'(DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + PW'(1);
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + (PW+1)'(1);
        2'b01:   count_q <= count_q - (PW+1)'(1);
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== rtl/sbl_back.sv =====
// Window engine: pixel ring memory, 3x3 gather, Sobel gradients and iterative root.
`include "sobel_edge_magnitude_3x3_assert.svh"

module sbl_back #(
  parameter int MAXW = 2048,
  parameter int AW   = 13
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          mem_we_i,
  input  logic [AW-1:0]                 mem_waddr_i,
  input  logic [sbl_pkg::PIX_W-1:0]     mem_wdata_i,
  input  logic [$clog2(MAXW+1)-1:0]     width_i,
  input  logic                          empty_i,
  output logic                          pop_o,
  input  sbl_pkg::sbl_flags_t           cmd_flags_i,
  input  logic [AW-1:0]                 cmd_center_i,
  sbl_out_if.source                     res_o
);

  localparam int TAPS = sbl_pkg::WIN_TAPS;
  localparam int PW   = sbl_pkg::PIX_W;

  sbl_pkg::sbl_back_e state_q, state_d;

  logic [PW-1:0]       line_mem_q [2**AW];
  logic [PW-1:0]       rd_data_q;
  logic [PW-1:0]       win_q [TAPS];
  logic [3:0]          cnt_q;
  logic [2:0]          bit_q;
  logic [AW-1:0]       center_q;
  sbl_pkg::sbl_flags_t flags_q;
  logic signed [10:0]  gx_q;
  logic signed [10:0]  gy_q;
  logic [19:0]         sq_q;
  logic [20:0]         acc_q;
  logic [7:0]          root_q;
  logic                out_valid_q;
  logic [PW-1:0]       edge_q;
  logic                last_q;

  logic [AW-1:0]       wa;
  logic [AW-1:0]       rd_addr;
  logic [3:0]          tap;
  logic                tap_ok;
  logic [PW-1:0]       tap_data;
  logic [9:0]          sum_xp;
  logic [9:0]          sum_xn;
  logic [9:0]          sum_yp;
  logic [9:0]          sum_yn;
  logic signed [10:0]  gx_d;
  logic signed [10:0]  gy_d;
  logic signed [10:0]  mul_a;
  logic signed [21:0]  prod;
  logic [7:0]          trial;
  logic [15:0]         trial_sq;
  logic                sat;
  logic [PW-1:0]       result;
  logic                slot_free;
  logic                load;

  assign wa = AW'(width_i);

  always_comb begin
    case (cnt_q)
      4'd0:    rd_addr = center_q - wa - AW'(1);
      4'd1:    rd_addr = center_q - wa;
      4'd2:    rd_addr = center_q - wa + AW'(1);
      4'd3:    rd_addr = center_q - AW'(1);
      4'd5:    rd_addr = center_q + AW'(1);
      4'd6:    rd_addr = center_q + wa - AW'(1);
      4'd7:    rd_addr = center_q + wa;
      4'd8:    rd_addr = center_q + wa + AW'(1);
      default: rd_addr = center_q;
    endcase
  end

  assign tap = cnt_q - 4'd1;

  always_comb begin
    case (tap)
      4'd5:    tap_ok = flags_q.right_ok;
      4'd6:    tap_ok = flags_q.bl_ok;
      4'd7:    tap_ok = flags_q.b_ok;
      4'd8:    tap_ok = flags_q.br_ok;
      default: tap_ok = 1'b1;
    endcase
  end

  assign tap_data = tap_ok ? rd_data_q : '0;

  assign sum_xp = 10'(win_q[2]) + 10'(sbl_pkg::SIDE_WEIGHT) * 10'(win_q[5]) + 10'(win_q[8]);
  assign sum_xn = 10'(win_q[0]) + 10'(sbl_pkg::SIDE_WEIGHT) * 10'(win_q[3]) + 10'(win_q[6]);
  assign sum_yp = 10'(win_q[0]) + 10'(sbl_pkg::SIDE_WEIGHT) * 10'(win_q[1]) + 10'(win_q[2]);
  assign sum_yn = 10'(win_q[6]) + 10'(sbl_pkg::SIDE_WEIGHT) * 10'(win_q[7]) + 10'(win_q[8]);
  assign gx_d   = $signed({1'b0, sum_xp}) - $signed({1'b0, sum_xn});
  assign gy_d   = $signed({1'b0, sum_yp}) - $signed({1'b0, sum_yn});

  assign mul_a    = (state_q == sbl_pkg::BS_SQX) ? gx_q : gy_q;
  assign prod     = mul_a * mul_a;
  assign trial    = root_q | (8'd1 << bit_q);
  assign trial_sq = 16'(trial) * 16'(trial);
  assign sat      = (acc_q[20:16] != '0);
  assign result   = flags_q.border ? win_q[4] : (sat ? 8'hFF : root_q);
  assign slot_free = !out_valid_q || res_o.ready;

  always_comb begin
    state_d = state_q;
    case (state_q)
      sbl_pkg::BS_IDLE: begin
        if (!empty_i) begin
          state_d = sbl_pkg::BS_READ;
        end
      end
      sbl_pkg::BS_READ: begin
        if (cnt_q == 4'(TAPS)) begin
          state_d = flags_q.border ? sbl_pkg::BS_HOLD : sbl_pkg::BS_GRAD;
        end
      end
      sbl_pkg::BS_GRAD: state_d = sbl_pkg::BS_SQX;
      sbl_pkg::BS_SQX:  state_d = sbl_pkg::BS_SQY;
      sbl_pkg::BS_SQY:  state_d = sbl_pkg::BS_SUM;
      sbl_pkg::BS_SUM:  state_d = sbl_pkg::BS_ROOT;
      sbl_pkg::BS_ROOT: begin
        if (bit_q == '0) begin
          state_d = sbl_pkg::BS_HOLD;
        end
      end
      sbl_pkg::BS_HOLD: begin
        if (slot_free) begin
          state_d = sbl_pkg::BS_IDLE;
        end
      end
      default: state_d = sbl_pkg::BS_IDLE;
    endcase
  end

  always_comb begin
    pop_o            = (state_q == sbl_pkg::BS_IDLE) && !empty_i;
    load             = (state_q == sbl_pkg::BS_HOLD) && slot_free;
    res_o.valid      = out_valid_q;
    res_o.edge_out   = edge_q;
    res_o.frame_last = last_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sbl_pkg::BS_IDLE;
      cnt_q       <= '0;
      bit_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (pop_o) begin
        cnt_q <= '0;
      end else if (state_q == sbl_pkg::BS_READ) begin
        cnt_q <= cnt_q + 4'd1;
      end
      if (state_q == sbl_pkg::BS_SUM) begin
        bit_q <= 3'd7;
      end else if (state_q == sbl_pkg::BS_ROOT) begin
        bit_q <= bit_q - 3'd1;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      center_q <= cmd_center_i;
      flags_q  <= cmd_flags_i;
    end
    if ((state_q == sbl_pkg::BS_READ) && (cnt_q != '0)) begin
      for (int i = 0; i < TAPS - 1; i++) begin
        win_q[i] <= win_q[i+1];
      end
      win_q[TAPS-1] <= tap_data;
    end
    case (state_q)
      sbl_pkg::BS_GRAD: begin
        gx_q <= gx_d;
        gy_q <= gy_d;
      end
      sbl_pkg::BS_SQX: begin
        sq_q <= prod[19:0];
      end
      sbl_pkg::BS_SQY: begin
        sq_q  <= prod[19:0];
        acc_q <= {1'b0, sq_q};
      end
      sbl_pkg::BS_SUM: begin
        acc_q  <= acc_q + {1'b0, sq_q};
        root_q <= '0;
      end
      sbl_pkg::BS_ROOT: begin
        if (trial_sq <= acc_q[15:0]) begin
          root_q <= trial;
        end
      end
      default: begin
        root_q <= root_q;
      end
    endcase
    if (load) begin
      edge_q <= result;
      last_q <= flags_q.last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we_i) begin
      line_mem_q[mem_waddr_i] <= mem_wdata_i;
    end
    rd_data_q <= line_mem_q[rd_addr];
  end

  `SBL_ASSERT_IMPL(a_root_bound, clk_i, rst_ni, state_q == sbl_pkg::BS_ROOT,
                   16'(root_q) * 16'(root_q) <= acc_q[15:0], "partial root too large")
  `SBL_ASSERT_NEXT(a_pop_starts_read, clk_i, rst_ni, pop_o,
                   (state_q == sbl_pkg::BS_READ) && (cnt_q == 4'd0),
                   "command taken without starting the window gather")
  `SBL_ASSERT_IMPL(a_hold_after_gather, clk_i, rst_ni, state_q == sbl_pkg::BS_HOLD,
                   cnt_q == 4'(TAPS + 1), "result held before the window gather finished")

endmodule

// ===== rtl/sobel_edge_magnitude_3x3.sv =====
// Top level of the 3x3 Sobel edge magnitude block with its register port.
//
//   channel  direction  transfer when          payload
//   pix_i    in         valid && ready         op, pixel_in
//   res_o    out        valid && ready         edge_out, frame_last
//   apb      in/out     psel && penable        frame_width at 0x0, frame_height at 0x4
//
// Each result needs nine reads through the single ring memory port; an interior pixel
// then also takes the squares and an eight-step bit-serial square root. After reset
// and after every register write the position resync (a product and a 25-step
// division) holds ready low. A stalled output keeps its result while four commands
// queue up behind it.
module sobel_edge_magnitude_3x3 #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  sbl_in_if.sink      pix_i,
  sbl_out_if.source   res_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int WD = $clog2(MAX_WIDTH + 1);
  localparam int HD = $clog2(MAX_HEIGHT + 1);
  localparam int AW = $clog2(3 * MAX_WIDTH + 16);
  localparam int DW = $bits(sbl_pkg::sbl_flags_t) + AW;
  localparam int CWB = sbl_pkg::CFG_WIDTH_BITS;
  localparam int CHB = sbl_pkg::CFG_HEIGHT_BITS;

  logic [CWB-1:0]      width_q;
  logic [CHB-1:0]      height_q;
  logic                cfg_wr;
  logic [WD-1:0]       width_eff;
  logic [HD-1:0]       height_eff;

  logic                push;
  logic                pop;
  logic                full;
  logic                empty;
  sbl_pkg::sbl_flags_t cmd_flags;
  logic [AW-1:0]       cmd_center;
  logic [DW-1:0]       fifo_dout;
  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [sbl_pkg::PIX_W-1:0] mem_wdata;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CWB'(640);
      height_q <= CHB'(480);
    end else if (cfg_wr) begin
      case (paddr[2])
        sbl_pkg::REG_FRAME_WIDTH: width_q  <= pwdata[CWB-1:0];
        default:                  height_q <= pwdata[CHB-1:0];
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      sbl_pkg::REG_FRAME_WIDTH: prdata = 32'(width_q);
      default:                  prdata = 32'(height_q);
    endcase
  end

  assign width_eff  = (width_q == '0) ? WD'(1) :
                      ((32'(width_q) > 32'(MAX_WIDTH)) ? WD'(MAX_WIDTH) : WD'(width_q));
  assign height_eff = (height_q == '0) ? HD'(1) :
                      ((32'(height_q) > 32'(MAX_HEIGHT)) ? HD'(MAX_HEIGHT) : HD'(height_q));

  sbl_front #(
    .MAXW (MAX_WIDTH),
    .MAXH (MAX_HEIGHT),
    .AW   (AW)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_wr_i     (cfg_wr),
    .width_i      (width_eff),
    .height_i     (height_eff),
    .pix_i        (pix_i),
    .full_i       (full),
    .push_o       (push),
    .cmd_flags_o  (cmd_flags),
    .cmd_center_o (cmd_center),
    .mem_we_o     (mem_we),
    .mem_waddr_o  (mem_waddr),
    .mem_wdata_o  (mem_wdata)
  );

  sbl_fifo #(
    .DW (DW)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  ({cmd_flags, cmd_center}),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (fifo_dout),
    .empty_o (empty)
  );

  sbl_back #(
    .MAXW (MAX_WIDTH),
    .AW   (AW)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .mem_we_i     (mem_we),
    .mem_waddr_i  (mem_waddr),
    .mem_wdata_i  (mem_wdata),
    .width_i      (width_eff),
    .empty_i      (empty),
    .pop_o        (pop),
    .cmd_flags_i  (sbl_pkg::sbl_flags_t'(fifo_dout[DW-1:AW])),
    .cmd_center_i (fifo_dout[AW-1:0]),
    .res_o        (res_o)
  );

endmodule
